@@ hw/rtl/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and codes for the streaming pattern replace block: payload
// structs, configuration register indexes and cell control groups.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

    // configuration port geometry
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // one input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    // one output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } t_out_item;

    // control for one lookahead window cell
    typedef struct packed {
        logic at_tail;  // this cell is the next free slot
        logic wr;       // an input transaction is accepted
        logic shift;    // take the neighbor's view
    } t_wcell_ctl;

    // control for one output burst cell
    typedef struct packed {
        logic load;     // parallel load of a new burst
        logic shift;    // move toward the output end
    } t_bcell_ctl;

endpackage : spr_pkg

`default_nettype wire

@@ hw/rtl/spr_win_cell.sv @@
// ----------------------------------------------------------------------------
// spr_win_cell
// One byte slot of the lookahead window. Shows its byte with the incoming
// byte appended, compares it to its pattern byte and shifts in its
// neighbor's view when the oldest byte leaves the window.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_win_cell
    import spr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_wcell_ctl i_ctl,
    input  wire logic [7:0] i_new_byte,
    input  wire logic [7:0] i_nbr_view,
    input  wire logic [7:0] i_pat_byte,
    output logic      [7:0] o_view,
    output logic            o_match
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // contents as seen with the incoming byte appended
    assign o_view  = i_ctl.at_tail ? i_new_byte : r_byte;
    assign o_match = (o_view == i_pat_byte);

    // shift from neighbor or capture the incoming byte
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_nbr_view;
        end else if (i_ctl.wr && i_ctl.at_tail) begin
            n_byte = i_new_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule : spr_win_cell

`default_nettype wire

@@ hw/rtl/spr_burst_cell.sv @@
// ----------------------------------------------------------------------------
// spr_burst_cell
// One slot of the output burst buffer. Loads a byte in parallel with its
// neighbors and then passes it one slot toward the output per result.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_burst_cell
    import spr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_bcell_ctl i_ctl,
    input  wire logic [7:0] i_load_byte,
    input  wire logic [7:0] i_nbr_byte,
    output logic      [7:0] o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // load wins over shift
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.load) begin
            n_byte = i_load_byte;
        end else if (i_ctl.shift) begin
            n_byte = i_nbr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule : spr_burst_cell

`default_nettype wire

@@ hw/rtl/stream_pattern_replace_core.sv @@
// ----------------------------------------------------------------------------
// stream_pattern_replace_core
// Streaming find and replace. Text enters one byte per transaction and every
// non-overlapping occurrence of the configured pattern (1 to MAX_PATTERN
// bytes), found left to right, leaves as the configured replacement (0 to
// MAX_REPLACEMENT bytes); the leftover lookahead bytes are flushed at end of
// text, and a text that ends with nothing to emit yields one byte-less end
// marker. The row of window cells compares and shifts in the same cycle that
// an input transaction is taken and loads its results into a burst buffer
// that emits one result per cycle into an output register while the output
// is not stalled. A byte that yields at most one result therefore sustains
// one transaction per cycle when the output is not stalled, and one that
// yields more than one result holds the input while the burst buffer emits them.
// A result passes the burst buffer and then the output register. Configuration
// must be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_pattern_replace_core
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // text input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    // result output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data
);

    localparam int BURST_D = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                             : MAX_REPLACEMENT;
    localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W   = $clog2(BURST_D + 1);
    localparam logic [LEN_W-1:0] PMAX = LEN_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0] RMAX = LEN_W'(MAX_REPLACEMENT);

    // configuration registers
    logic [8*MAX_PATTERN-1:0]     r_pat;
    logic [LEN_W-1:0]             r_plen;
    logic [8*MAX_REPLACEMENT-1:0] r_repl;
    logic [LEN_W-1:0]             r_rlen;

    // window and burst control state
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [CNT_W-1:0]  r_bcnt;
    logic [CNT_W-1:0]  n_bcnt;
    logic              r_bmark;
    logic              r_beot;
    logic              r_ov;
    t_out_item         r_out;

    logic [FILL_W-1:0] eff_plen;
    logic [CNT_W-1:0]  eff_rlen;
    logic [FILL_W-1:0] fill_inc;
    logic              in_acc;
    logic              eot;
    logic              b_adv;
    logic              hit_all;
    logic              hit;
    logic              marker;
    logic [CNT_W-1:0]  n_res;
    logic              b_load;

    logic [7:0]             view [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] match;
    logic [7:0]             b_byte [BURST_D];
    logic [7:0]             ld_byte [BURST_D];
    t_wcell_ctl             wctl [MAX_PATTERN];
    t_bcell_ctl             bctl;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= LEN_W'(1);
            r_repl <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_BYTES:      r_pat  <= i_cfg_wdata[8*MAX_PATTERN-1:0];
                CFG_PATTERN_LENGTH:     r_plen <= i_cfg_wdata[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_repl <= i_cfg_wdata[8*MAX_REPLACEMENT-1:0];
                CFG_REPLACEMENT_LENGTH: r_rlen <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective lengths: zero pattern length acts as one, both saturate
    always_comb begin
        if (r_plen == '0) begin
            eff_plen = FILL_W'(1);
        end else if (r_plen > PMAX) begin
            eff_plen = FILL_W'(MAX_PATTERN);
        end else begin
            eff_plen = FILL_W'(r_plen);
        end
        if (r_rlen > RMAX) begin
            eff_rlen = CNT_W'(MAX_REPLACEMENT);
        end else begin
            eff_rlen = CNT_W'(r_rlen);
        end
    end

    // handshakes: burst buffer drains into the output register
    assign b_adv      = (r_bcnt != '0) && (!r_ov || !i_out_stall);
    assign o_in_stall = !((r_bcnt == '0) || ((r_bcnt == CNT_W'(1)) && b_adv));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign eot        = i_in_data.end_of_text;
    assign fill_inc   = r_fill + FILL_W'(1);

    // row of window cells
    for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_win
        logic [7:0] nbr;
        if (gi == MAX_PATTERN - 1) begin : g_last
            assign nbr = i_in_data.in_byte;
        end else begin : g_mid
            assign nbr = view[gi+1];
        end
        assign wctl[gi].at_tail = (r_fill == FILL_W'(gi));
        assign wctl[gi].wr      = in_acc;
        assign wctl[gi].shift   = in_acc && !hit && !eot && (fill_inc >= eff_plen);

        spr_win_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (wctl[gi]),
            .i_new_byte (i_in_data.in_byte),
            .i_nbr_view (nbr),
            .i_pat_byte (r_pat[8*gi +: 8]),
            .o_view     (view[gi]),
            .o_match    (match[gi])
        );
    end

    // full window against pattern
    always_comb begin
        hit_all = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((FILL_W'(i) < eff_plen) && !match[i]) begin
                hit_all = 1'b0;
            end
        end
    end
    assign hit = (fill_inc == eff_plen) && hit_all;

    // results caused by this transaction
    always_comb begin
        marker = 1'b0;
        if (hit) begin
            if ((eff_rlen == '0) && eot) begin
                n_res  = CNT_W'(1);
                marker = 1'b1;
            end else begin
                n_res = eff_rlen;
            end
        end else if (eot) begin
            n_res = CNT_W'(fill_inc);
        end else if (fill_inc >= eff_plen) begin
            n_res = CNT_W'(1);
        end else begin
            n_res = '0;
        end
    end
    assign b_load = in_acc && (n_res != '0);

    // window fill
    always_comb begin
        n_fill = r_fill;
        if (in_acc) begin
            if (hit || eot) begin
                n_fill = '0;
            end else if (fill_inc < eff_plen) begin
                n_fill = fill_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // burst buffer cells
    assign bctl.load  = b_load;
    assign bctl.shift = b_adv;

    for (genvar gk = 0; gk < BURST_D; gk++) begin : g_burst
        logic [7:0] repl_k;
        logic [7:0] view_k;
        logic [7:0] nbr;
        if (gk < MAX_REPLACEMENT) begin : g_rep
            assign repl_k = r_repl[8*gk +: 8];
        end else begin : g_rep_none
            assign repl_k = '0;
        end
        if (gk < MAX_PATTERN) begin : g_view
            assign view_k = view[gk];
        end else begin : g_view_none
            assign view_k = '0;
        end
        if (gk == BURST_D - 1) begin : g_last
            assign nbr = '0;
        end else begin : g_mid
            assign nbr = b_byte[gk+1];
        end
        assign ld_byte[gk] = marker ? 8'h00 : (hit ? repl_k : view_k);

        spr_burst_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (bctl),
            .i_load_byte (ld_byte[gk]),
            .i_nbr_byte  (nbr),
            .o_byte      (b_byte[gk])
        );
    end

    // burst count and flags
    always_comb begin
        n_bcnt = r_bcnt;
        if (b_load) begin
            n_bcnt = n_res;
        end else if (b_adv) begin
            n_bcnt = r_bcnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
        end else begin
            r_bcnt <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_bmark <= marker;
            r_beot  <= eot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (b_adv) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out.out_byte   <= b_byte[0];
            r_out.byte_valid <= !r_bmark;
            r_out.run_last   <= (r_bcnt == CNT_W'(1));
            r_out.text_end   <= r_beot && (r_bcnt == CNT_W'(1));
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // checks
    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(MAX_PATTERN))
        else $error("window fill reached its depth");

    a_bcnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= CNT_W'(BURST_D))
        else $error("burst count beyond buffer depth");

    a_eot_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && eot |=> r_fill == '0)
        else $error("window not emptied at end of text");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.text_end |-> r_out.run_last)
        else $error("text end without run last");

    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_out.byte_valid |-> r_out.text_end && (r_out.out_byte == 8'h00))
        else $error("end marker in the middle of a text");

endmodule : stream_pattern_replace_core

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for stream_pattern_replace_core. Directed texts cover replacement,
// deletion, the bare end marker, length saturation and a pattern shrink in
// the middle of a text. Random texts are then built mostly from pattern
// occurrences, with broken prefixes and noise mixed in, under several
// configurations and idle/stall mixes. Each accepted input transaction runs
// through a bench-side model whose results are queued and compared field by
// field against every accepted output transaction.
// ----------------------------------------------------------------------------

module tb;
    import spr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAXP         = 8;
    localparam int MAXR         = 8;

    // stimulus side signals
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    t_cfg_idx         cfg_idx   = CFG_PATTERN_BYTES;
    logic [63:0]      cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_data;

    // bench copy of the block state and registers
    logic [7:0]       win_mem [0:MAXP-1] = '{default: 8'h00};
    int               win_fill  = 0;
    logic [63:0]      pat_bytes = '0;
    logic [3:0]       pat_len   = 4'd1;
    logic [63:0]      rep_bytes = '0;
    logic [3:0]       rep_len   = 4'd0;

    t_out_item        exp_q[$];
    int               errors         = 0;
    int               cycles         = 0;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;

    stream_pattern_replace_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("stream_pattern_replace_core regression: fail");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // one emitted character
    function automatic t_out_item char_result(input logic [7:0] b);
        t_out_item r;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.run_last   = 1'b0;
        r.text_end   = 1'b0;
        return r;
    endfunction

    // drop the oldest window byte
    function automatic void shift_window();
        int k;
        for (k = 1; k < win_fill && k < MAXP; k++)
            win_mem[k-1] = win_mem[k];
        if (win_fill > 0)
            win_fill--;
    endfunction

    // expected output transactions for one input transaction
    function automatic void predict_text(input t_in_item it);
        t_out_item res[$];
        t_out_item last_res;
        int        plen;
        int        rlen;
        int        k;
        bit        hit;
        plen = int'(pat_len);
        if (plen == 0) plen = 1;
        if (plen > MAXP) plen = MAXP;
        rlen = int'(rep_len);
        if (rlen > MAXR) rlen = MAXR;

        if (win_fill >= MAXP) begin
            res.push_back(char_result(win_mem[0]));
            shift_window();
        end
        win_mem[win_fill] = it.in_byte;
        win_fill++;

        // compare only when the window holds exactly one pattern length
        if (win_fill == plen) begin
            hit = 1'b1;
            for (k = 0; k < plen; k++)
                if (win_mem[k] != pat_bytes[8*k +: 8]) hit = 1'b0;
            if (hit) begin
                for (k = 0; k < rlen; k++)
                    res.push_back(char_result(rep_bytes[8*k +: 8]));
                win_fill = 0;
            end else begin
                res.push_back(char_result(win_mem[0]));
                shift_window();
            end
        end else if (win_fill > plen) begin
            res.push_back(char_result(win_mem[0]));
            shift_window();
        end

        // flush at end of text, bare marker when nothing is left
        if (it.end_of_text) begin
            for (k = 0; k < win_fill && k < MAXP && res.size() < 8; k++)
                res.push_back(char_result(win_mem[k]));
            win_fill = 0;
            if (res.size() == 0) begin
                last_res = char_result(8'h00);
                last_res.byte_valid = 1'b0;
                res.push_back(last_res);
            end
            last_res = res.pop_back();
            last_res.text_end = 1'b1;
            res.push_back(last_res);
        end
        if (res.size() > 0) begin
            last_res = res.pop_back();
            last_res.run_last = 1'b1;
            res.push_back(last_res);
        end
        for (k = 0; k < res.size(); k++)
            exp_q.push_back(res[k]);
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (exp_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none actual %h", $time, got);
        end else begin
            want = exp_q.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
            compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
            compare_field("text_end", 8'(want.text_end), 8'(got.text_end));
        end
    endtask

    // monitor: register writes, accepted inputs, accepted outputs
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_PATTERN_BYTES:      pat_bytes = cfg_wdata;
                    CFG_PATTERN_LENGTH:     pat_len   = cfg_wdata[3:0];
                    CFG_REPLACEMENT_BYTES:  rep_bytes = cfg_wdata;
                    CFG_REPLACEMENT_LENGTH: rep_len   = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_text(in_data);
            if (out_valid && !out_stall)
                check_result(out_data);
        end
    end

    // one input transaction with random leading gap
    task automatic send_char(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, eot};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // send n bytes, first byte in bits 7..0
    task automatic send_bytes(input logic [63:0] s, input int n, input bit eot_last);
        int k;
        for (k = 0; k < n; k++)
            send_char(s[8*k +: 8], eot_last && (k == n - 1));
    endtask

    // sender pauses until every expected transaction has arrived
    task automatic wait_idle();
        in_valid <= 1'b0;
        // let the monitor log the last accepted input first
        @(posedge clk);
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write all four registers
    task automatic configure(input logic [63:0] pb, input logic [63:0] pl,
                             input logic [63:0] rb, input logic [63:0] rl);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_PATTERN_BYTES;
        cfg_wdata <= pb;
        @(posedge clk);
        cfg_idx   <= CFG_PATTERN_LENGTH;
        cfg_wdata <= pl;
        @(posedge clk);
        cfg_idx   <= CFG_REPLACEMENT_BYTES;
        cfg_wdata <= rb;
        @(posedge clk);
        cfg_idx   <= CFG_REPLACEMENT_LENGTH;
        cfg_wdata <= rl;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // two-byte pattern to three-byte replacement, overlap and extreme bytes
    task automatic test_replace_basic();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(64'h6261, 64'd2, 64'h5A5958, 64'd3);
        send_bytes(64'h0062_61FF_6261_6100, 7, 1'b1);
        wait_idle();
    endtask

    // deletion, bare end marker and silent input mid-text
    task automatic test_end_marker();
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        configure(64'h41, 64'd1, 64'hA5, 64'd0);
        send_bytes(64'h41, 1, 1'b1);
        send_bytes(64'h41, 1, 1'b0);
        send_bytes(64'h41, 1, 1'b1);
        wait_idle();
    endtask

    // lengths above the maximum saturate, pattern length zero acts as one
    task automatic test_length_saturation();
        send_idle_pct  = 0;
        recv_stall_pct = 36;
        configure(64'h0807_0605_0403_0201, 64'hF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hF);
        send_bytes(64'h0807_0605_0403_0201, 8, 1'b1);
        wait_idle();
        configure(64'h0, 64'd0, 64'h80, 64'd1);
        send_bytes(64'h00, 1, 1'b1);
        wait_idle();
    endtask

    // pattern shrunk while the window holds more bytes than the new length
    task automatic test_shrink_mid_text();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(64'h7A79_7877, 64'd4, 64'h0, 64'd0);
        send_bytes(64'h79_7877, 3, 1'b0);
        wait_idle();
        configure(64'h71, 64'd1, 64'h2A2B, 64'd2);
        send_bytes(64'h7271, 2, 1'b1);
        wait_idle();
    endtask

    // random texts across configurations and idle/stall mixes
    task automatic test_random_texts();
        int          phase;
        int          s;
        int          sent;
        int          len;
        int          tl;
        int          k;
        int          j;
        int          r;
        int          pl_n;
        int          rl_n;
        int          plen_eff;
        logic [63:0] pb;
        logic [63:0] rb;
        logic [63:0] pl_w;
        logic [63:0] rl_w;
        logic [7:0]  alpha;
        logic [7:0]  ch;
        logic [7:0]  txt [0:31];
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (s = 0; s < 2; s++) begin
                // length settings, extremes first
                case (phase * 2 + s)
                    0: begin pl_n = 1;  rl_n = 0;  end
                    1: begin pl_n = 8;  rl_n = 8;  end
                    2: begin pl_n = 3;  rl_n = 1;  end
                    3: begin pl_n = 15; rl_n = 15; end
                    4: begin pl_n = 0;  rl_n = 9;  end
                    5: begin pl_n = 2;  rl_n = 8;  end
                    6: begin pl_n = $urandom_range(1, 8); rl_n = $urandom_range(0, 8); end
                    default: begin pl_n = 5; rl_n = 2; end
                endcase
                pl_w = {$urandom, $urandom};
                rl_w = {$urandom, $urandom};
                if ($urandom_range(0, 1)) pl_w[63:4] = '0;
                if ($urandom_range(0, 1)) rl_w[63:4] = '0;
                pl_w[3:0] = pl_n[3:0];
                rl_w[3:0] = rl_n[3:0];
                plen_eff = (pl_n == 0) ? 1 : (pl_n > MAXP) ? MAXP : pl_n;

                // pattern mostly from a small alphabet so text can hit it
                alpha = 8'($urandom_range(0, 255));
                for (k = 0; k < 8; k++) begin
                    if ($urandom_range(0, 4) != 0)
                        ch = alpha + 8'($urandom_range(0, 2));
                    else
                        ch = 8'($urandom_range(0, 255));
                    pb[8*k +: 8] = ch;
                end
                rb = {$urandom, $urandom};

                wait_idle();
                configure(pb, pl_w, rb, rl_w);

                sent = 0;
                while (sent < 20) begin
                    len = $urandom_range(1, 14);
                    tl  = 0;
                    while (tl < len) begin
                        r = $urandom_range(0, 9);
                        if (r < 4) begin
                            // whole pattern occurrence
                            for (j = 0; j < plen_eff; j++) begin
                                txt[tl] = pb[8*j +: 8];
                                tl++;
                            end
                        end else if (r < 5) begin
                            // broken occurrence: prefix then a stray char
                            j = $urandom_range(0, plen_eff - 1);
                            for (k = 0; k < j; k++) begin
                                txt[tl] = pb[8*k +: 8];
                                tl++;
                            end
                            txt[tl] = alpha + 8'($urandom_range(0, 2));
                            tl++;
                        end else if (r < 8) begin
                            txt[tl] = alpha + 8'($urandom_range(0, 2));
                            tl++;
                        end else begin
                            txt[tl] = 8'($urandom_range(0, 255));
                            tl++;
                        end
                    end
                    for (k = 0; k < tl; k++)
                        send_char(txt[k], k == tl - 1);
                    sent += tl;
                end
            end
        end
        wait_idle();
    endtask

    // sequence
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_replace_basic();
        test_end_marker();
        test_length_saturation();
        test_shrink_mid_text();
        test_random_texts();
        wait_idle();
        if (errors == 0 && exp_q.size() == 0) begin
            $display("stream_pattern_replace_core regression: pass");
        end else begin
            $display("stream_pattern_replace_core regression: fail");
        end
        $finish;
    end

endmodule
